// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL. Defining ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/tlpt_pkg.sv -----
`default_nettype none

package tlpt_pkg;

	// Field widths of one transaction.
	localparam int VADDR_W = 32;
	localparam int FRAME_W = 20;
	localparam int FLAGS_W = 12;
	localparam int ENTRY_W = 32;

	// Address split: directory index in bits 31:22, table index in bits 21:12.
	localparam int DIDX_W      = 10;
	localparam int TIDX_W      = 10;
	localparam int DIDX_LSB    = 22;
	localparam int TIDX_LSB    = 12;
	localparam int DIR_ENTRIES = 1024;
	localparam int ENTRIES_PER_TABLE = 1024;

	// Operation codes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_MAP    = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIR  = 2'b10
	} tlpt_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlpt_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/two_level_page_table_map_lookup_unit.sv -----
`default_nettype none

// Two-level page table held in two on-chip RAMs: a directory RAM of 1024
// entries (present bit and table slot) and a table RAM of TABLE_SLOTS * 1024
// 32-bit entries. A transaction is accepted when start is high and busy is
// low. Its result appears on entry and failed with done high for exactly one
// cycle. The accept registers the transaction into the directory state, and
// done is registered from that state. The receiver cannot hold it off: it
// must take it in that cycle. Busy stays high while the transaction is in
// the directory state, so a new transaction cannot start until the directory
// stage of the last is over. This is set by the directory RAM read followed
// by the dependent table RAM read or write. After reset, busy stays high while
// both RAMs are swept to zero, one entry per cycle. Table slots are handed
// out in order and never freed; a map that needs a new slot when none
// remain returns entry zero with failed set.
module two_level_page_table_map_lookup_unit #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic                           op,
	input  wire logic [tlpt_pkg::VADDR_W-1:0]   vaddr,
	input  wire logic [tlpt_pkg::FRAME_W-1:0]   frame_number,
	input  wire logic [tlpt_pkg::FLAGS_W-1:0]   entry_flags,
	output      logic                           done,
	output      logic [tlpt_pkg::ENTRY_W-1:0]   entry,
	output      logic                           failed
);

	import tlpt_pkg::*;

	localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int NF_W      = $clog2(TABLE_SLOTS + 1);
	localparam int DIR_W     = SLOT_W + 1;
	localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int TBL_LAST  = TBL_DEPTH - 1;

	logic                 accept;
	tlpt_state_t          st_q;
	logic                 clearing_q;
	logic [TBL_AW-1:0]    clr_cnt_q;
	logic [NF_W-1:0]      nf_q;

	// Captured transaction.
	logic                 op_s1;
	logic [DIDX_W-1:0]    didx_s1;
	logic [TIDX_W-1:0]    tidx_s1;
	logic [FRAME_W-1:0]   frame_s1;
	logic [FLAGS_W-1:0]   flags_s1;

	// Result registers.
	logic                 done_q;
	logic                 failed_q;
	logic                 from_tbl_q;
	logic [ENTRY_W-1:0]   entry_q;

	// RAM ports.
	logic                 dir_we;
	logic [DIDX_W-1:0]    dir_waddr;
	logic [DIR_W-1:0]     dir_wdata;
	logic [DIR_W-1:0]     dir_rdata;
	logic                 tbl_we;
	logic [TBL_AW-1:0]    tbl_waddr;
	logic [ENTRY_W-1:0]   tbl_wdata;
	logic                 tbl_re;
	logic [ENTRY_W-1:0]   tbl_rdata;

	// Directory-stage decode.
	logic                 in_dir;
	logic                 dir_present;
	logic [SLOT_W-1:0]    dir_slot;
	logic                 has_slot;
	logic                 map_new;
	logic                 map_fail;
	logic                 map_wr;
	logic                 lookup_rd;
	logic [SLOT_W-1:0]    use_slot;
	logic [TBL_AW-1:0]    tbl_op_addr;
	logic [ENTRY_W-1:0]   new_entry;

	assign accept = start && !busy;
	assign busy   = clearing_q || (st_q == ST_DIR);
	assign in_dir = (st_q == ST_DIR);

	// Decode the directory entry read for the transaction in flight.
	always_comb begin
		dir_present = dir_rdata[SLOT_W];
		dir_slot    = dir_rdata[SLOT_W-1:0];
		has_slot    = nf_q < NF_W'(TABLE_SLOTS);
		map_new     = in_dir && (op_s1 == OP_MAP) && !dir_present && has_slot;
		map_fail    = in_dir && (op_s1 == OP_MAP) && !dir_present && !has_slot;
		map_wr      = in_dir && (op_s1 == OP_MAP) && (dir_present || has_slot);
		lookup_rd   = in_dir && (op_s1 == OP_LOOKUP) && dir_present;
		use_slot    = dir_present ? dir_slot : SLOT_W'(nf_q);
		tbl_op_addr = TBL_AW'({use_slot, tidx_s1});
		new_entry   = {frame_s1, flags_s1};
	end

	// RAM write ports: the reset sweep has priority, then map writes.
	always_comb begin
		if (clearing_q) begin
			dir_we    = 1'b1;
			dir_waddr = clr_cnt_q[DIDX_W-1:0];
			dir_wdata = '0;
			tbl_we    = 1'b1;
			tbl_waddr = clr_cnt_q;
			tbl_wdata = '0;
		end else begin
			dir_we    = map_new;
			dir_waddr = didx_s1;
			dir_wdata = {1'b1, SLOT_W'(nf_q)};
			tbl_we    = map_wr;
			tbl_waddr = tbl_op_addr;
			tbl_wdata = new_entry;
		end
	end

	assign tbl_re = lookup_rd;

	tlpt_ram #(
		.WIDTH(DIR_W),
		.DEPTH(DIR_ENTRIES)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (accept),
		.raddr (vaddr[DIDX_LSB +: DIDX_W]),
		.rdata (dir_rdata)
	);

	tlpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_op_addr),
		.rdata (tbl_rdata)
	);

	// Reset sweep over both RAMs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == TBL_AW'(TBL_LAST)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Sequencer and slot allocator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			nf_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (map_new) begin
				nf_q <= nf_q + 1'b1;
			end
		end
	end

	// Capture the transaction fields at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			didx_s1  <= vaddr[DIDX_LSB +: DIDX_W];
			tidx_s1  <= vaddr[TIDX_LSB +: TIDX_W];
			frame_s1 <= frame_number;
			flags_s1 <= entry_flags;
		end
	end

	// Result strobe and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			failed_q   <= 1'b0;
			from_tbl_q <= 1'b0;
		end else begin
			done_q     <= in_dir;
			failed_q   <= map_fail;
			from_tbl_q <= lookup_rd;
		end
	end

	// Result value for maps and absent lookups.
	always_ff @(posedge clk) begin
		if (in_dir) begin
			entry_q <= map_wr ? new_entry : '0;
		end
	end

	// A lookup that hit takes its value straight from the table RAM output.
	assign done   = done_q;
	assign failed = failed_q;
	assign entry  = from_tbl_q ? tbl_rdata : entry_q;

`include "assert_macros.svh"

	// Every accepted transaction yields its result strobe on done.
	`ASSERT_CLK(a_result_timing, clk, arst_n, accept |-> ##2 done)
	// A failed map reports a zero entry.
	`ASSERT_CLK(a_fail_zero, clk, arst_n, failed |-> (entry == '0))
	// The allocator never hands out more slots than exist.
	`ASSERT_NEVER(a_slot_bound, clk, arst_n, nf_q > NF_W'(TABLE_SLOTS))
	// No result and no new slot while the RAMs are being swept.
	`ASSERT_NEVER(a_quiet_clear, clk, arst_n, clearing_q && (done || map_new))

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
	import tlpt_pkg::*;

	localparam int TABLE_SLOTS    = 16;
	localparam int SLOT_W         = $clog2(TABLE_SLOTS);
	localparam int RANDOM_ITEMS   = 1650;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct {
		logic               op;
		logic [VADDR_W-1:0] vaddr;
		logic [FRAME_W-1:0] frame;
		logic [FLAGS_W-1:0] flags;
		int                 idle_pct;
		bit                 drain;
	} walk_req_t;

	typedef struct {
		logic [ENTRY_W-1:0] entry;
		logic               failed;
	} walk_resp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_LOOKUP;
	logic [VADDR_W-1:0] vaddr = '0;
	logic [FRAME_W-1:0] frame_number = '0;
	logic [FLAGS_W-1:0] entry_flags = '0;
	logic               done;
	logic [ENTRY_W-1:0] entry;
	logic               failed;

	wire req_fire = start && !busy;

	walk_req_t  pending_q[$];
	walk_resp_t expected_q[$];
	walk_resp_t want_resp;
	int         n_accepted;
	int         n_answered;
	int         n_errors;
	int         stall_cycles;

	// Shadow copy of the directory, the table RAM and the slot allocator.
	bit                 dir_valid [DIR_ENTRIES];
	bit [SLOT_W-1:0]    dir_slot_of [DIR_ENTRIES];
	bit [ENTRY_W-1:0]   pte_mem [TABLE_SLOTS*ENTRIES_PER_TABLE];
	int                 slots_used;

	two_level_page_table_map_lookup_unit #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.vaddr       (vaddr),
		.frame_number(frame_number),
		.entry_flags (entry_flags),
		.done        (done),
		.entry       (entry),
		.failed      (failed)
	);

	// Walks the shadow page table for one transaction and updates it on a map.
	function automatic walk_resp_t walk_table(walk_req_t req);
		walk_resp_t       resp;
		logic [DIDX_W-1:0] didx;
		logic [TIDX_W-1:0] tidx;
		resp.entry  = '0;
		resp.failed = 1'b0;
		didx = req.vaddr[DIDX_LSB +: DIDX_W];
		tidx = req.vaddr[TIDX_LSB +: TIDX_W];
		if (req.op == OP_LOOKUP) begin
			if (dir_valid[didx])
				resp.entry = pte_mem[{dir_slot_of[didx], tidx}];
		end else begin
			// An absent directory entry takes the next slot, if any is left.
			if (!dir_valid[didx]) begin
				if (slots_used < TABLE_SLOTS) begin
					dir_slot_of[didx] = slots_used[SLOT_W-1:0];
					dir_valid[didx]   = 1'b1;
					slots_used++;
				end else begin
					resp.failed = 1'b1;
				end
			end
			if (!resp.failed) begin
				resp.entry = {req.frame, req.flags};
				pte_mem[{dir_slot_of[didx], tidx}] = resp.entry;
			end
		end
		return resp;
	endfunction

	function automatic void queue_req(logic req_op, logic [VADDR_W-1:0] va,
			logic [FRAME_W-1:0] frame, logic [FLAGS_W-1:0] flags, int idle_pct, bit drain);
		walk_req_t req;
		req.op       = req_op;
		req.vaddr    = va;
		req.frame    = frame;
		req.flags    = flags;
		req.idle_pct = idle_pct;
		req.drain    = drain;
		pending_q.push_back(req);
	endfunction

	// Clock and the single reset at the start of the run.
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: presents the oldest pending transaction and predicts it on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start        <= 1'b0;
			op           <= OP_LOOKUP;
			vaddr        <= '0;
			frame_number <= '0;
			entry_flags  <= '0;
			n_accepted   <= 0;
		end else begin
			if (req_fire) begin
				expected_q.push_back(walk_table(pending_q[0]));
				void'(pending_q.pop_front());
				n_accepted <= n_accepted + 1;
			end
			if (start && !req_fire) begin
				// Held by busy: keep the transaction on the ports.
			end else if (pending_q.size() != 0 &&
					!(pending_q[0].drain && (req_fire || n_accepted != n_answered)) &&
					$urandom_range(99) >= pending_q[0].idle_pct) begin
				start        <= 1'b1;
				op           <= pending_q[0].op;
				vaddr        <= pending_q[0].vaddr;
				frame_number <= pending_q[0].frame;
				entry_flags  <= pending_q[0].flags;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each result strobe is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_answered <= 0;
		end else if (done) begin
			n_answered <= n_answered + 1;
			if (expected_q.size() == 0) begin
				$error("unexpected result: entry %h failed %b", entry, failed);
				n_errors++;
			end else begin
				want_resp = expected_q.pop_front();
				if (entry !== want_resp.entry) begin
					$error("entry mismatch: expected %h, got %h", want_resp.entry, entry);
					n_errors++;
				end
				if (failed !== want_resp.failed) begin
					$error("failed mismatch: expected %b, got %b", want_resp.failed, failed);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: the limit covers the table sweep after reset and long sender gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if (req_fire || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int                unsigned live_dirs[$];
		int                unsigned tidx_pool[8];
		int                phase_idle[4];
		int                phase_len;
		int                idle;
		logic [DIDX_W-1:0] didx;
		logic [TIDX_W-1:0] tidx;
		logic [VADDR_W-1:0] va;
		logic              req_op;

		tidx_pool  = '{0, 1023, 1, 512, 77, 300, 901, 1022};
		phase_idle = '{0, 80, 0, 36};
		phase_len  = RANDOM_ITEMS / 4;

		// Lookups before anything is mapped return zero.
		queue_req(OP_LOOKUP, 32'h0000_0000, '0, '0, 0, 1'b0);
		queue_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, 1'b0);
		// Extremes of the fields, then lookups with ignored offset bits.
		queue_req(OP_MAP, 32'h0000_0000, '0, '0, 0, 1'b0);
		queue_req(OP_MAP, 32'hFFFF_FFFF, '1, '1, 0, 1'b0);
		queue_req(OP_LOOKUP, 32'hFFFF_FABC, '0, '0, 0, 1'b0);
		queue_req(OP_LOOKUP, 32'h0000_0FFF, '1, '1, 0, 1'b0);
		// Remapping an address overwrites its entry.
		queue_req(OP_MAP, 32'hFFFF_F123, 20'h12345, 12'h5A5, 0, 1'b0);
		queue_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 0, 1'b0);
		// A present directory with an untouched table entry reads zero.
		queue_req(OP_LOOKUP, 32'hFFC0_1000, '0, '0, 0, 1'b0);
		live_dirs.push_back(0);
		live_dirs.push_back(1023);

		// Use up the remaining table slots.
		for (int k = 1; k <= TABLE_SLOTS - 2; k++) begin
			didx = DIDX_W'(k * 70 + 3);
			live_dirs.push_back(k * 70 + 3);
			va = {didx, TIDX_W'($urandom), FLAGS_W'($urandom)};
			queue_req(OP_MAP, va, FRAME_W'($urandom), FLAGS_W'($urandom), 0, 1'b0);
		end

		// Out of slots: a map to a new directory fails and leaves it absent.
		queue_req(OP_MAP, {10'd1000, 10'd5, 12'h0}, '1, '1, 0, 1'b1);
		queue_req(OP_LOOKUP, {10'd1000, 10'd5, 12'h0}, '0, '0, 0, 1'b0);

		// Random part: mostly live directories and a few hot table indexes.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle   = phase_idle[(i / phase_len) % 4];
			req_op = ($urandom_range(1) == 0) ? OP_LOOKUP : OP_MAP;
			if ($urandom_range(99) < 20) begin
				va = $urandom;
			end else begin
				didx = DIDX_W'(live_dirs[$urandom_range(live_dirs.size() - 1)]);
				if ($urandom_range(99) < 60)
					tidx = TIDX_W'(tidx_pool[$urandom_range(7)]);
				else
					tidx = TIDX_W'($urandom);
				va = {didx, tidx, FLAGS_W'($urandom)};
			end
			queue_req(req_op, va, FRAME_W'($urandom), FLAGS_W'($urandom), idle,
				(i % phase_len == 0) || ($urandom_range(99) == 0));
		end

		@(posedge arst_n);
		while (pending_q.size() != 0 || n_accepted != n_answered)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_q.size() != 0) begin
			$error("%0d transactions never produced a result", expected_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ram.sv
rtl/core/two_level_page_table_map_lookup_unit.sv
tb/testbench.sv
